>>> hw/rtl/rtcb_pkg.sv
// ----------------------------------------------------------------------------
// rtcb_pkg: shared types and constants for the RTC timestamp beacon packer
// Register map codes, payload structs, pipeline widths and calendar tables.
// ----------------------------------------------------------------------------
package rtcb_pkg;

    // calendar and time constants
    localparam logic [31:0] JDN_2000      = 32'd2451545;
    localparam logic [31:0] JDN_OFFSET    = 32'd32045;
    localparam logic [31:0] DAY_BIAS      = JDN_2000 + JDN_OFFSET;
    localparam logic [31:0] UNIX_AT_2000  = 32'd946684800;
    localparam int          RTC_HZ        = 32768;
    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam int          YEAR_BIAS     = 4800;
    localparam logic [12:0] YEAR_BASE     = 13'(2000 + YEAR_BIAS);
    localparam logic [9:0]  MS_PER_SEC    = 10'd1000;
    localparam logic [14:0] SYNC_DEFAULT  = 15'd255;
    localparam logic [6:0]  ASYNC_DEFAULT = 7'd127;
    localparam logic [3:0]  NIBBLE_MASK   = 4'hF;

    // reciprocal multipliers, exact over the ranges used
    localparam logic [12:0] DIV100_MUL    = 13'd5243;
    localparam int          DIV100_SHIFT  = 19;
    localparam logic [24:0] DIV1000_MUL   = 25'd17179870;
    localparam int          DIV1000_SHIFT = 34;

    // datapath widths
    localparam int FREQ_W     = 15;
    localparam int ASYNC_W    = 7;
    localparam int DIV_W      = 32;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = DIV_W / DIV_STEP;
    localparam int MS_W       = 24;
    localparam int MSQ_W      = 15;
    localparam int SPT_W      = 8;

    // register indexes
    localparam logic [2:0] REG_STATION_ID = 3'd0;
    localparam logic [2:0] REG_EVENT_NUM  = 3'd1;
    localparam logic [2:0] REG_COUNTRY    = 3'd2;
    localparam logic [2:0] REG_RSSI       = 3'd3;
    localparam logic [2:0] REG_SYNC_PS    = 3'd4;
    localparam logic [2:0] REG_ASYNC_PS   = 3'd5;

    typedef struct packed {
        logic [11:0] station_id;
        logic [19:0] event_number;
        logic [7:0]  event_country;
        logic [7:0]  rssi_threshold;
        logic [14:0] sync_prescaler;
        logic [6:0]  async_prescaler;
    } cfg_t;

    typedef struct packed {
        logic [6:0]  year_in_century;
        logic [3:0]  month_num;
        logic [4:0]  day_of_month;
        logic [4:0]  hour_num;
        logic [5:0]  minute_num;
        logic [5:0]  second_num;
        logic [15:0] subsecond_count;
    } reading_t;

    typedef struct packed {
        logic [47:0] payload_bytes;
        logic        is_race_frame;
    } result_t;

    typedef struct packed {
        logic [DIV_W-1:0]  num_ms;
        logic [DIV_W-1:0]  num_spt;
        logic [FREQ_W-1:0] freq;
        logic [31:0]       cal;
    } div_item_t;

    typedef struct packed {
        logic [DIV_W-1:0] q_ms;
        logic [DIV_W-1:0] q_spt;
        logic [31:0]      cal;
    } div_res_t;

    // days before month m of a March-based year: (153*m + 2) / 5
    function automatic logic [8:0] month_days(input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            4'd12:   d = 9'd367;
            4'd13:   d = 9'd398;
            4'd14:   d = 9'd428;
            default: d = 9'd459;
        endcase
        return d;
    endfunction

endpackage

>>> hw/rtl/rtcb_front.sv
// ----------------------------------------------------------------------------
// rtcb_front: date to seconds and divider operand setup
// Three stages: operand prep, day count, seconds since 2000.
// ----------------------------------------------------------------------------
module rtcb_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                vld,
    input  rtcb_pkg::reading_t  reading,
    input  rtcb_pkg::cfg_t      cfg,
    output logic                item_vld,
    output rtcb_pkg::div_item_t item
);

    localparam int FREQ_N = 2 ** rtcb_pkg::ASYNC_W;

    // tick frequency per async prescaler
    logic [rtcb_pkg::FREQ_W-1:0] freq_tab [FREQ_N];

    for (genvar i = 0; i < FREQ_N; i++)
    begin : g_freq
        localparam logic [rtcb_pkg::FREQ_W-1:0] F =
            rtcb_pkg::FREQ_W'(rtcb_pkg::RTC_HZ / (i + 1));
        assign freq_tab[i] = F;
    end

    // stage 1
    logic [14:0] ps;
    logic [6:0]  pa;
    logic        early;
    logic [3:0]  m;
    logic [12:0] y;
    logic [31:0] diff;
    logic [25:0] yh_prod;
    logic [16:0] hms;

    logic                        s1_vld_reg;
    logic [rtcb_pkg::FREQ_W-1:0] s1_freq_reg;
    logic [15:0]                 s1_ps1_reg;
    logic [31:0]                 s1_num_ms_reg;
    logic [12:0]                 s1_y_reg;
    logic [6:0]                  s1_yh_reg;
    logic [8:0]                  s1_t_reg;
    logic [4:0]                  s1_day_reg;
    logic [16:0]                 s1_hms_reg;

    always_comb
    begin
        ps = (cfg.sync_prescaler == '0) ? rtcb_pkg::SYNC_DEFAULT : cfg.sync_prescaler;
        pa = (cfg.async_prescaler == '0) ? rtcb_pkg::ASYNC_DEFAULT : cfg.async_prescaler;
        early = (reading.month_num <= 4'd2);
        m = early ? 4'(reading.month_num + 4'd9) : 4'(reading.month_num - 4'd3);
        y = 13'(rtcb_pkg::YEAR_BASE + 13'(reading.year_in_century)) - 13'(early);
        diff = {17'd0, ps} - {16'd0, reading.subsecond_count};
        yh_prod = 26'(y) * 26'(rtcb_pkg::DIV100_MUL);
        hms = 17'(17'(reading.hour_num) * 17'd3600)
            + 17'(17'(reading.minute_num) * 17'd60)
            + 17'(reading.second_num);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= vld;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_freq_reg   <= freq_tab[pa];
        s1_ps1_reg    <= 16'(ps) + 16'd1;
        s1_num_ms_reg <= diff * 32'(rtcb_pkg::MS_PER_SEC);
        s1_y_reg      <= y;
        s1_yh_reg     <= yh_prod[25:rtcb_pkg::DIV100_SHIFT];
        s1_t_reg      <= rtcb_pkg::month_days(m);
        s1_day_reg    <= reading.day_of_month;
        s1_hms_reg    <= hms;
    end

    // stage 2: day number relative to 2000-01-01
    logic [31:0] days_next;

    logic                        s2_vld_reg;
    logic [31:0]                 s2_days_reg;
    logic [16:0]                 s2_hms_reg;
    logic [31:0]                 s2_num_ms_reg;
    logic [15:0]                 s2_ps1_reg;
    logic [rtcb_pkg::FREQ_W-1:0] s2_freq_reg;

    always_comb
    begin
        days_next = 32'(s1_day_reg) + 32'(s1_t_reg)
                  + 32'(s1_y_reg) * 32'd365
                  + 32'(s1_y_reg >> 2)
                  - 32'(s1_yh_reg)
                  + 32'(s1_yh_reg >> 2)
                  - rtcb_pkg::DAY_BIAS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_days_reg   <= days_next;
        s2_hms_reg    <= s1_hms_reg;
        s2_num_ms_reg <= s1_num_ms_reg;
        s2_ps1_reg    <= s1_ps1_reg;
        s2_freq_reg   <= s1_freq_reg;
    end

    // stage 3: seconds since 2000, wraps mod 2^32
    rtcb_pkg::div_item_t s3_item_next;
    rtcb_pkg::div_item_t s3_item_reg;
    logic                s3_vld_reg;

    always_comb
    begin
        s3_item_next.cal     = s2_days_reg * 32'(rtcb_pkg::SECS_PER_DAY) + 32'(s2_hms_reg);
        s3_item_next.num_ms  = s2_num_ms_reg;
        s3_item_next.num_spt = rtcb_pkg::DIV_W'(s2_ps1_reg);
        s3_item_next.freq    = s2_freq_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_item_reg <= s3_item_next;
    end

    assign item_vld = s3_vld_reg;
    assign item     = s3_item_reg;

endmodule

>>> hw/rtl/rtcb_div.sv
// ----------------------------------------------------------------------------
// rtcb_div: pipelined restoring divider, two lanes sharing one divisor
// Lane 0 gives milliseconds, lane 1 seconds per tick; four quotient bits per lane per stage.
// ----------------------------------------------------------------------------
module rtcb_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_vld,
    input  rtcb_pkg::div_item_t item,
    output logic                res_vld,
    output rtcb_pkg::div_res_t  res
);

    localparam int N  = rtcb_pkg::DIV_STAGES;
    localparam int DW = rtcb_pkg::DIV_W;
    localparam int FW = rtcb_pkg::FREQ_W;

    typedef struct packed {
        logic [1:0][DW-1:0] dq;   // dividend bits shift out, quotient bits shift in
        logic [1:0][FW-1:0] rem;
        logic [FW-1:0]      freq;
        logic [31:0]        cal;
    } div_stage_t;

    div_stage_t     src     [N];
    div_stage_t     st_next [N];
    div_stage_t     st_reg  [N];
    logic [N-1:0]   vld_reg;

    always_comb
    begin
        src[0].dq[0] = item.num_ms;
        src[0].dq[1] = item.num_spt;
        src[0].rem   = '0;
        src[0].freq  = item.freq;
        src[0].cal   = item.cal;
        for (int s = 1; s < N; s++)
        begin
            src[s] = st_reg[s-1];
        end
    end

    always_comb
    begin
        div_stage_t  cur;
        logic [FW:0] tmp;
        for (int s = 0; s < N; s++)
        begin
            cur = src[s];
            for (int l = 0; l < 2; l++)
            begin
                for (int k = 0; k < rtcb_pkg::DIV_STEP; k++)
                begin
                    tmp = {cur.rem[l], cur.dq[l][DW-1]};
                    cur.dq[l] = {cur.dq[l][DW-2:0], 1'b0};
                    if (tmp >= {1'b0, cur.freq})
                    begin
                        cur.rem[l]   = FW'(tmp - {1'b0, cur.freq});
                        cur.dq[l][0] = 1'b1;
                    end
                    else
                    begin
                        cur.rem[l] = tmp[FW-1:0];
                    end
                end
            end
            st_next[s] = cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[N-2:0], item_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < N; s++)
        begin
            st_reg[s] <= st_next[s];
        end
    end

    assign res_vld   = vld_reg[N-1];
    assign res.q_ms  = st_reg[N-1].dq[0];
    assign res.q_spt = st_reg[N-1].dq[1];
    assign res.cal   = st_reg[N-1].cal;

endmodule

>>> hw/rtl/rtcb_pack.sv
// ----------------------------------------------------------------------------
// rtcb_pack: Unix time assembly and beacon payload packing
// Three stages: tick scaling, Unix time, tenths and frame select.
// ----------------------------------------------------------------------------
module rtcb_pack (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_vld,
    input  rtcb_pkg::div_res_t res,
    input  rtcb_pkg::cfg_t     cfg,
    output logic               done,
    output rtcb_pkg::result_t  result
);

    localparam int MSW  = rtcb_pkg::MS_W;
    localparam int MSQW = rtcb_pkg::MSQ_W;
    localparam int SW   = rtcb_pkg::SPT_W;
    localparam int PW   = MSW + 25;

    // stage 1: cal * seconds per tick, ms / 1000 by reciprocal
    logic [SW-1:0]   spt;
    logic [PW-1:0]   msq_prod;

    logic            p1_vld_reg;
    logic [31:0]     p1_prod_reg;
    logic [MSQW-1:0] p1_msq_reg;
    logic [MSW-1:0]  p1_ms_reg;

    always_comb
    begin
        spt = (res.q_spt[SW-1:0] == '0) ? SW'(1) : res.q_spt[SW-1:0];
        msq_prod = PW'(res.q_ms[MSW-1:0]) * PW'(rtcb_pkg::DIV1000_MUL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= res_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_prod_reg <= res.cal * 32'(spt);
        p1_msq_reg  <= msq_prod[PW-1:rtcb_pkg::DIV1000_SHIFT];
        p1_ms_reg   <= res.q_ms[MSW-1:0];
    end

    // stage 2: Unix time and ms remainder
    logic [9:0]  rem_next;
    logic [31:0] unix_next;

    logic        p2_vld_reg;
    logic [9:0]  p2_rem_reg;
    logic [31:0] p2_unix_reg;

    always_comb
    begin
        rem_next  = 10'(p1_ms_reg - MSW'(MSW'(p1_msq_reg) * MSW'(rtcb_pkg::MS_PER_SEC)));
        unix_next = rtcb_pkg::UNIX_AT_2000 + p1_prod_reg + 32'(p1_msq_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_vld_reg <= 1'b0;
        end
        else
        begin
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p2_rem_reg  <= rem_next;
        p2_unix_reg <= unix_next;
    end

    // stage 3: tenths and frame select
    logic [22:0]       tprod;
    logic [3:0]        tenths;
    rtcb_pkg::result_t result_next;
    rtcb_pkg::result_t result_reg;
    logic              done_reg;

    always_comb
    begin
        tprod  = 23'(p2_rem_reg) * 23'(rtcb_pkg::DIV100_MUL);
        tenths = tprod[rtcb_pkg::DIV100_SHIFT+3:rtcb_pkg::DIV100_SHIFT] & rtcb_pkg::NIBBLE_MASK;
        result_next.is_race_frame = (cfg.station_id == '0);
        if (result_next.is_race_frame)
        begin
            result_next.payload_bytes = {12'h000, cfg.event_number,
                                         cfg.event_country, cfg.rssi_threshold};
        end
        else
        begin
            result_next.payload_bytes = {cfg.station_id, tenths, p2_unix_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= p2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> hw/rtl/rtc_timestamp_beacon_packer.sv
// ----------------------------------------------------------------------------
// rtc_timestamp_beacon_packer: RTC reading to 6-byte beacon payload
//
// Input: drive reading and pulse start; the item is taken when start is high
// and busy is low. busy never rises, so one item can enter every cycle.
// Output: done is high for one cycle with result holding the payload and the
// race frame flag. Results come out in order, after the item has passed 3 date
// stages, 8 divider stages at 4 quotient bits each and 3 packing stages;
// sustained throughput is one item per cycle.
// The receiver has no backpressure: every done cycle must be taken.
// Configuration: APB port, register i at byte address 4*i, pready tied high.
// Write the registers only while no item is in flight.
// Reset clears the pipeline valid bits and loads register defaults
// (prescalers 255 and 127, all others zero); items in flight are dropped.
// ----------------------------------------------------------------------------
module rtc_timestamp_beacon_packer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  rtcb_pkg::reading_t reading,
    output logic               done,
    output rtcb_pkg::result_t  result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int LATENCY = 14;

    rtcb_pkg::cfg_t      cfg_reg;
    logic [2:0]          reg_idx;
    logic                wr_en;
    logic                acc;
    logic                div_in_vld;
    rtcb_pkg::div_item_t div_in;
    logic                div_out_vld;
    rtcb_pkg::div_res_t  div_out;

    assign busy    = 1'b0;
    assign pready  = 1'b1;
    assign acc     = start && !busy;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.station_id      <= '0;
            cfg_reg.event_number    <= '0;
            cfg_reg.event_country   <= '0;
            cfg_reg.rssi_threshold  <= '0;
            cfg_reg.sync_prescaler  <= rtcb_pkg::SYNC_DEFAULT;
            cfg_reg.async_prescaler <= rtcb_pkg::ASYNC_DEFAULT;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                rtcb_pkg::REG_STATION_ID: cfg_reg.station_id      <= pwdata[11:0];
                rtcb_pkg::REG_EVENT_NUM:  cfg_reg.event_number    <= pwdata[19:0];
                rtcb_pkg::REG_COUNTRY:    cfg_reg.event_country   <= pwdata[7:0];
                rtcb_pkg::REG_RSSI:       cfg_reg.rssi_threshold  <= pwdata[7:0];
                rtcb_pkg::REG_SYNC_PS:    cfg_reg.sync_prescaler  <= pwdata[14:0];
                rtcb_pkg::REG_ASYNC_PS:   cfg_reg.async_prescaler <= pwdata[6:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            rtcb_pkg::REG_STATION_ID: prdata = 32'(cfg_reg.station_id);
            rtcb_pkg::REG_EVENT_NUM:  prdata = 32'(cfg_reg.event_number);
            rtcb_pkg::REG_COUNTRY:    prdata = 32'(cfg_reg.event_country);
            rtcb_pkg::REG_RSSI:       prdata = 32'(cfg_reg.rssi_threshold);
            rtcb_pkg::REG_SYNC_PS:    prdata = 32'(cfg_reg.sync_prescaler);
            rtcb_pkg::REG_ASYNC_PS:   prdata = 32'(cfg_reg.async_prescaler);
            default:                  prdata = '0;
        endcase
    end

    rtcb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld      (acc),
        .reading  (reading),
        .cfg      (cfg_reg),
        .item_vld (div_in_vld),
        .item     (div_in)
    );

    rtcb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_vld (div_in_vld),
        .item     (div_in),
        .res_vld  (div_out_vld),
        .res      (div_out)
    );

    rtcb_pack u_pack (
        .clk     (clk),
        .rst_n   (rst_n),
        .res_vld (div_out_vld),
        .res     (div_out),
        .cfg     (cfg_reg),
        .done    (done),
        .result  (result)
    );

    // every taken item comes out after the fixed pipeline depth
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        acc |-> ##LATENCY done)
        else $error("item did not come out at pipeline depth");

    // no result without an item taken at pipeline depth earlier
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(acc, LATENCY))
        else $error("result without matching item");

    // tenths digit stays a decimal digit
    a_tenths: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.is_race_frame) |-> (result.payload_bytes[35:32] <= 4'd9))
        else $error("tenths out of range");

    // race frame keeps its leading byte and nibble clear
    a_race: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_race_frame) |-> (result.payload_bytes[47:36] == 12'h000))
        else $error("race frame header not clear");

endmodule
